### hdl/rmj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared constants, types and arithmetic steps of the radar Jacobian core.
// ----------------------------------------------------------------------------
package rmj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int Q_W       = 64;
  localparam int N_W       = 2 * Q_W;
  localparam int CFG_W     = 40;
  localparam int SQRT_W    = Q_W / 2;

  localparam logic [CFG_W-1:0] MIN_SQ_RST = 40'd429497;

  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W;
  localparam int MUL_LAT   = 2;
  localparam int SQRT_LAT  = Q_W / 2;
  localparam int SIDE_DLY  = 2 * DIV_LAT + MUL_LAT + SQRT_LAT;
  localparam int TAP_Q     = DIV_LAT - 1;
  localparam int TAP_R     = DIV_LAT + SQRT_LAT - 1;
  localparam int DLY_Q     = MUL_LAT + DIV_LAT + SQRT_LAT;
  localparam int DLY_R     = MUL_LAT + DIV_LAT;
  localparam int OUT_LAT   = FRONT_LAT + SIDE_DLY + 1;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic reject;
    logic negx;
    logic negy;
    logic cneg;
  } rmj_side_t;

  typedef struct packed {
    logic [Q_W-1:0] rem;
    logic [Q_W-1:0] low;
    logic [Q_W-1:0] quo;
  } rmj_div_st_t;

  typedef struct packed {
    logic [Q_W-1:0] v;
    logic [Q_W-1:0] res;
  } rmj_sqrt_st_t;

  // One restoring division step; the shifted remainder is one bit wider than
  // the divisor so that a carry out of the top counts as a subtraction.
  function automatic rmj_div_st_t div_step(input logic [Q_W-1:0] rem,
                                           input logic [Q_W-1:0] low,
                                           input logic [Q_W-1:0] quo,
                                           input logic [Q_W-1:0] den);
    logic [Q_W:0] sh;
    logic [Q_W:0] dif;
    logic         take;
    rmj_div_st_t  st;
    sh   = {rem, low[Q_W-1]};
    dif  = sh - {1'b0, den};
    take = (sh >= {1'b0, den});
    st.rem = take ? dif[Q_W-1:0] : sh[Q_W-1:0];
    st.low = {low[Q_W-2:0], 1'b0};
    st.quo = {quo[Q_W-2:0], take};
    return st;
  endfunction

  function automatic rmj_sqrt_st_t sqrt_step(input logic [Q_W-1:0] v,
                                             input logic [Q_W-1:0] res,
                                             input logic [Q_W-1:0] bt);
    logic [Q_W-1:0] t;
    rmj_sqrt_st_t   st;
    t = res + bt;
    if (v >= t) begin
      st.v   = v - t;
      st.res = (res >> 1) + bt;
    end else begin
      st.v   = v;
      st.res = res >> 1;
    end
    return st;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic [Q_W-1:0] mag,
                                              input logic neg,
                                              input logic over);
    logic [Q_W-1:0] ng;
    logic [DATA_W-1:0] r;
    ng = '0 - mag;
    if (neg) begin
      if (over || (mag > {32'd0, SAT_NEG})) r = SAT_NEG;
      else r = ng[DATA_W-1:0];
    end else begin
      if (over || (mag > {32'd0, SAT_POS})) r = SAT_POS;
      else r = mag[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/rmj_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined 128 by 64 bit unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmj_div (
  input  wire logic                 clk,
  input  wire logic [rmj_pkg::N_W-1:0] num_i,
  input  wire logic [rmj_pkg::Q_W-1:0] den_i,
  output logic [rmj_pkg::Q_W-1:0]   quo_o,
  output logic                      over_o,
  output logic [rmj_pkg::Q_W-1:0]   den_o
);
  import rmj_pkg::*;

  logic [Q_W-1:0] rem_r [DIV_LAT];
  logic [Q_W-1:0] low_r [DIV_LAT];
  logic [Q_W-1:0] quo_r [DIV_LAT];
  logic [Q_W-1:0] den_r [DIV_LAT];
  logic [DIV_LAT-1:0] ovr_r;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [Q_W-1:0] rem_in, low_in, quo_in, den_in;
    logic           ovr_in;
    rmj_div_st_t    st_nxt;
    if (k == 0) begin : g_first
      // The quotient needs more than 64 bits when the top half reaches the divisor.
      assign rem_in = num_i[N_W-1:Q_W];
      assign low_in = num_i[Q_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign ovr_in = (num_i[N_W-1:Q_W] >= den_i);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
      assign ovr_in = ovr_r[k-1];
    end
    assign st_nxt = div_step(rem_in, low_in, quo_in, den_in);
    always_ff @(posedge clk) begin
      rem_r[k] <= st_nxt.rem;
      low_r[k] <= st_nxt.low;
      quo_r[k] <= st_nxt.quo;
      den_r[k] <= den_in;
      ovr_r[k] <= ovr_in;
    end
  end

  assign quo_o  = quo_r[DIV_LAT-1];
  assign over_o = ovr_r[DIV_LAT-1];
  assign den_o  = den_r[DIV_LAT-1];

endmodule
`default_nettype wire

### hdl/rmj_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined 64 bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmj_sqrt (
  input  wire logic                    clk,
  input  wire logic [rmj_pkg::Q_W-1:0] val_i,
  output logic [rmj_pkg::SQRT_W-1:0]   root_o
);
  import rmj_pkg::*;

  logic [Q_W-1:0] v_r   [SQRT_LAT];
  logic [Q_W-1:0] res_r [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [Q_W-1:0] v_in, res_in;
    rmj_sqrt_st_t   st_nxt;
    if (k == 0) begin : g_first
      assign v_in   = val_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
    end
    assign st_nxt = sqrt_step(v_in, res_in, Q_W'(1) << (Q_W - 2 - 2 * k));
    always_ff @(posedge clk) begin
      v_r[k]   <= st_nxt.v;
      res_r[k] <= st_nxt.res;
    end
  end

  assign root_o = res_r[SQRT_LAT-1][SQRT_W-1:0];

endmodule
`default_nettype wire

### hdl/rmj_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_mul
// Two stage 64 bit squarer built from 32 by 32 bit partial products.
// ----------------------------------------------------------------------------
module rmj_mul (
  input  wire logic                    clk,
  input  wire logic [rmj_pkg::Q_W-1:0] val_i,
  output logic [rmj_pkg::N_W-1:0]      sq_o
);
  import rmj_pkg::*;

  logic [Q_W-1:0] pll_r, phh_r, plh_r;
  logic [N_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    pll_r <= val_i[31:0] * val_i[31:0];
    phh_r <= val_i[63:32] * val_i[63:32];
    plh_r <= val_i[31:0] * val_i[63:32];
    // The cross term appears twice, hence the shift by 33.
    sq_r  <= {phh_r, pll_r} + ({64'd0, plh_r} << 33);
  end

  assign sq_o = sq_r;

endmodule
`default_nettype wire

### hdl/rmj_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_front
// Squares, squared range, cross term and the dividends for the divider bank.
// ----------------------------------------------------------------------------
module rmj_front (
  input  wire logic                       clk,
  input  wire logic signed [31:0]         pos_x_i,
  input  wire logic signed [31:0]         pos_y_i,
  input  wire logic signed [31:0]         vel_x_i,
  input  wire logic signed [31:0]         vel_y_i,
  input  wire logic [rmj_pkg::CFG_W-1:0]  min_sq_i,
  output rmj_pkg::rmj_side_t              side_o,
  output logic [rmj_pkg::Q_W-1:0]         q_o,
  output logic [rmj_pkg::N_W-1:0]         n_xr_o,
  output logic [rmj_pkg::N_W-1:0]         n_yr_o,
  output logic [rmj_pkg::N_W-1:0]         n_xq_o,
  output logic [rmj_pkg::N_W-1:0]         n_yq_o,
  output logic [rmj_pkg::N_W-1:0]         n_ua_o,
  output logic [rmj_pkg::N_W-1:0]         n_ub_o
);
  import rmj_pkg::*;

  // stage 1
  logic signed [63:0] sqx1_r, sqy1_r, p1_r, p2_r;
  logic [31:0]        ax1_r, ay1_r;
  logic               nx1_r, ny1_r;
  // stage 2
  logic [Q_W-1:0]     q2_r, sqx2_r, sqy2_r;
  logic signed [64:0] dif2_r;
  logic [31:0]        ax2_r, ay2_r;
  logic               nx2_r, ny2_r;
  // stage 3
  logic [Q_W-1:0]     q3_r, sqx3_r, sqy3_r, cmag3_r;
  logic [31:0]        ax3_r, ay3_r;
  rmj_side_t          side3_r;
  // stage 4
  logic [Q_W-1:0]     q4_r, sqx4_r, sqy4_r;
  logic [Q_W-1:0]     pal4_r, pah4_r, pbl4_r, pbh4_r;
  logic [31:0]        ax4_r, ay4_r;
  rmj_side_t          side4_r;
  // stage 5
  rmj_side_t          side5_r;
  logic [Q_W-1:0]     q5_r;
  logic [N_W-1:0]     n_xr5_r, n_yr5_r, n_xq5_r, n_yq5_r, n_ua5_r, n_ub5_r;

  logic [64:0]        dif_neg;
  logic               cneg;
  rmj_side_t          side3_nxt;

  assign cneg    = dif2_r[64];
  assign dif_neg = ~dif2_r + 65'd1;

  always_comb begin
    side3_nxt.reject = (q2_r == '0) || (q2_r < {{(Q_W-CFG_W){1'b0}}, min_sq_i});
    side3_nxt.negx   = nx2_r;
    side3_nxt.negy   = ny2_r;
    side3_nxt.cneg   = cneg;
  end

  always_ff @(posedge clk) begin
    sqx1_r <= pos_x_i * pos_x_i;
    sqy1_r <= pos_y_i * pos_y_i;
    p1_r   <= vel_x_i * pos_y_i;
    p2_r   <= vel_y_i * pos_x_i;
    ax1_r  <= pos_x_i[31] ? (~pos_x_i + 32'd1) : pos_x_i;
    ay1_r  <= pos_y_i[31] ? (~pos_y_i + 32'd1) : pos_y_i;
    nx1_r  <= pos_x_i[31];
    ny1_r  <= pos_y_i[31];

    q2_r   <= sqx1_r + sqy1_r;
    sqx2_r <= sqx1_r;
    sqy2_r <= sqy1_r;
    dif2_r <= {p1_r[63], p1_r} - {p2_r[63], p2_r};
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    nx2_r  <= nx1_r;
    ny2_r  <= ny1_r;

    q3_r    <= q2_r;
    sqx3_r  <= sqx2_r;
    sqy3_r  <= sqy2_r;
    cmag3_r <= cneg ? dif_neg[63:0] : dif2_r[63:0];
    ax3_r   <= ax2_r;
    ay3_r   <= ay2_r;
    side3_r <= side3_nxt;

    q4_r    <= q3_r;
    sqx4_r  <= sqx3_r;
    sqy4_r  <= sqy3_r;
    pal4_r  <= ay3_r * cmag3_r[31:0];
    pah4_r  <= ay3_r * cmag3_r[63:32];
    pbl4_r  <= ax3_r * cmag3_r[31:0];
    pbh4_r  <= ax3_r * cmag3_r[63:32];
    ax4_r   <= ax3_r;
    ay4_r   <= ay3_r;
    side4_r <= side3_r;

    side5_r <= side4_r;
    q5_r    <= q4_r;
    n_xr5_r <= {64'd0, sqx4_r} << (2 * FRAC_BITS);
    n_yr5_r <= {64'd0, sqy4_r} << (2 * FRAC_BITS);
    n_xq5_r <= {96'd0, ax4_r} << (2 * FRAC_BITS);
    n_yq5_r <= {96'd0, ay4_r} << (2 * FRAC_BITS);
    n_ua5_r <= ({32'd0, pah4_r, 32'd0} + {64'd0, pal4_r}) << FRAC_BITS;
    n_ub5_r <= ({32'd0, pbh4_r, 32'd0} + {64'd0, pbl4_r}) << FRAC_BITS;
  end

  assign side_o = side5_r;
  assign q_o    = q5_r;
  assign n_xr_o = n_xr5_r;
  assign n_yr_o = n_yr5_r;
  assign n_xq_o = n_xq5_r;
  assign n_yq_o = n_yq5_r;
  assign n_ua_o = n_ua5_r;
  assign n_ub_o = n_ub5_r;

endmodule
`default_nettype wire

### hdl/radar_measurement_jacobian_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core
// Radar measurement Jacobian of a constant-velocity state in Q16.16.
// ----------------------------------------------------------------------------
// A state is taken in every clock cycle at which start is high; busy is never
// raised. Each result appears on the out_ ports for exactly one cycle, marked
// by out_valid, and must be taken then. The path runs through the five front
// stages, two 64 stage dividers in series, the squarer and the 32 stage square
// root. The threshold register may be written only while no transaction is in
// flight.
module radar_measurement_jacobian_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [31:0]         in_pos_x,
  input  wire logic signed [31:0]         in_pos_y,
  input  wire logic signed [31:0]         in_vel_x,
  input  wire logic signed [31:0]         in_vel_y,
  output logic                            out_valid,
  output logic signed [31:0]              out_d_range_d_px,
  output logic signed [31:0]              out_d_range_d_py,
  output logic signed [31:0]              out_d_bearing_d_px,
  output logic signed [31:0]              out_d_bearing_d_py,
  output logic signed [31:0]              out_d_rate_d_px,
  output logic signed [31:0]              out_d_rate_d_py,
  output logic signed [31:0]              out_d_rate_d_vx,
  output logic signed [31:0]              out_d_rate_d_vy,
  output logic                            out_too_close,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [rmj_pkg::CFG_W-1:0]  cfg_data
);
  import rmj_pkg::*;

  logic [CFG_W-1:0]   min_sq_r;
  logic [OUT_LAT-1:0] vld_r;

  rmj_side_t      fr_side;
  logic [Q_W-1:0] fr_q;
  logic [N_W-1:0] n_xr, n_yr, n_xq, n_yq, n_ua, n_ub;

  logic [Q_W-1:0] xr_quo, yr_quo, xq_quo, yq_quo, ua_quo, ub_quo;
  logic           xr_ovr, yr_ovr, xq_ovr, yq_ovr, ua_ovr, ub_ovr;
  logic [Q_W-1:0] xr_den, yr_den, xq_den, yq_den, ua_den, ub_den;
  logic [SQRT_W-1:0] xr_root, yr_root, ra_root, rb_root;
  logic [N_W-1:0] ua_sq, ub_sq;
  logic [Q_W-1:0] wa_quo, wb_quo, wa_den, wb_den;
  logic           wa_ovr, wb_ovr;

  rmj_side_t      side_dly_r [SIDE_DLY];
  logic [31:0]    xq_dly_r [DLY_Q];
  logic [31:0]    yq_dly_r [DLY_Q];
  logic [1:0]     ov1_dly_r [DLY_Q];
  logic [31:0]    xr_dly_r [DLY_R];
  logic [31:0]    yr_dly_r [DLY_R];
  logic [1:0]     ov2_dly_r [SQRT_LAT];
  logic [Q_W-1:0] q_dly_r [MUL_LAT];

  rmj_side_t      sq_tap, sr_tap, s_end;
  logic [31:0]    ra_val, rb_val;
  logic           accept;

  logic signed [31:0] rx_r, ry_r, bx_r, by_r, ra_r, rb_r;
  logic               tc_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sq_r <= MIN_SQ_RST;
      vld_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_sq_r <= cfg_data;
      end
      vld_r <= {vld_r[OUT_LAT-2:0], accept};
    end
  end

  rmj_front u_front (
    .clk(clk), .pos_x_i(in_pos_x), .pos_y_i(in_pos_y), .vel_x_i(in_vel_x),
    .vel_y_i(in_vel_y), .min_sq_i(min_sq_r), .side_o(fr_side), .q_o(fr_q),
    .n_xr_o(n_xr), .n_yr_o(n_yr), .n_xq_o(n_xq), .n_yq_o(n_yq),
    .n_ua_o(n_ua), .n_ub_o(n_ub)
  );

  rmj_div u_div_xr (.clk(clk), .num_i(n_xr), .den_i(fr_q), .quo_o(xr_quo),
                    .over_o(xr_ovr), .den_o(xr_den));
  rmj_div u_div_yr (.clk(clk), .num_i(n_yr), .den_i(fr_q), .quo_o(yr_quo),
                    .over_o(yr_ovr), .den_o(yr_den));
  rmj_div u_div_xq (.clk(clk), .num_i(n_xq), .den_i(fr_q), .quo_o(xq_quo),
                    .over_o(xq_ovr), .den_o(xq_den));
  rmj_div u_div_yq (.clk(clk), .num_i(n_yq), .den_i(fr_q), .quo_o(yq_quo),
                    .over_o(yq_ovr), .den_o(yq_den));
  rmj_div u_div_ua (.clk(clk), .num_i(n_ua), .den_i(fr_q), .quo_o(ua_quo),
                    .over_o(ua_ovr), .den_o(ua_den));
  rmj_div u_div_ub (.clk(clk), .num_i(n_ub), .den_i(fr_q), .quo_o(ub_quo),
                    .over_o(ub_ovr), .den_o(ub_den));

  rmj_sqrt u_sqrt_xr (.clk(clk), .val_i(xr_quo), .root_o(xr_root));
  rmj_sqrt u_sqrt_yr (.clk(clk), .val_i(yr_quo), .root_o(yr_root));

  rmj_mul u_mul_ua (.clk(clk), .val_i(ua_quo), .sq_o(ua_sq));
  rmj_mul u_mul_ub (.clk(clk), .val_i(ub_quo), .sq_o(ub_sq));

  rmj_div u_div_wa (.clk(clk), .num_i(ua_sq), .den_i(q_dly_r[MUL_LAT-1]),
                    .quo_o(wa_quo), .over_o(wa_ovr), .den_o(wa_den));
  rmj_div u_div_wb (.clk(clk), .num_i(ub_sq), .den_i(q_dly_r[MUL_LAT-1]),
                    .quo_o(wb_quo), .over_o(wb_ovr), .den_o(wb_den));

  rmj_sqrt u_sqrt_ra (.clk(clk), .val_i(wa_quo), .root_o(ra_root));
  rmj_sqrt u_sqrt_rb (.clk(clk), .val_i(wb_quo), .root_o(rb_root));

  assign sq_tap = side_dly_r[TAP_Q];
  assign sr_tap = side_dly_r[TAP_R];
  assign s_end  = side_dly_r[SIDE_DLY-1];

  // The rate entries saturate when either division overflowed.
  assign ra_val = sat32({32'd0, ra_root}, s_end.negy != s_end.cneg,
                        ov1_dly_r[DLY_Q-1][0] | ov2_dly_r[SQRT_LAT-1][0]);
  assign rb_val = sat32({32'd0, rb_root}, s_end.negx == s_end.cneg,
                        ov1_dly_r[DLY_Q-1][1] | ov2_dly_r[SQRT_LAT-1][1]);

  always_ff @(posedge clk) begin
    side_dly_r[0] <= fr_side;
    for (int i = 1; i < SIDE_DLY; i++) side_dly_r[i] <= side_dly_r[i-1];

    xq_dly_r[0]  <= sat32(xq_quo, sq_tap.negx, xq_ovr);
    yq_dly_r[0]  <= sat32(yq_quo, !sq_tap.negy, yq_ovr);
    ov1_dly_r[0] <= {ub_ovr, ua_ovr};
    for (int i = 1; i < DLY_Q; i++) begin
      xq_dly_r[i]  <= xq_dly_r[i-1];
      yq_dly_r[i]  <= yq_dly_r[i-1];
      ov1_dly_r[i] <= ov1_dly_r[i-1];
    end

    xr_dly_r[0] <= sat32({32'd0, xr_root}, sr_tap.negx, 1'b0);
    yr_dly_r[0] <= sat32({32'd0, yr_root}, sr_tap.negy, 1'b0);
    for (int i = 1; i < DLY_R; i++) begin
      xr_dly_r[i] <= xr_dly_r[i-1];
      yr_dly_r[i] <= yr_dly_r[i-1];
    end

    ov2_dly_r[0] <= {wb_ovr, wa_ovr};
    for (int i = 1; i < SQRT_LAT; i++) ov2_dly_r[i] <= ov2_dly_r[i-1];

    q_dly_r[0] <= ua_den;
    for (int i = 1; i < MUL_LAT; i++) q_dly_r[i] <= q_dly_r[i-1];

    tc_r <= s_end.reject;
    rx_r <= s_end.reject ? '0 : xr_dly_r[DLY_R-1];
    ry_r <= s_end.reject ? '0 : yr_dly_r[DLY_R-1];
    bx_r <= s_end.reject ? '0 : yq_dly_r[DLY_Q-1];
    by_r <= s_end.reject ? '0 : xq_dly_r[DLY_Q-1];
    ra_r <= s_end.reject ? '0 : ra_val;
    rb_r <= s_end.reject ? '0 : rb_val;
  end

  assign out_valid          = vld_r[OUT_LAT-1];
  assign out_d_range_d_px   = rx_r;
  assign out_d_range_d_py   = ry_r;
  assign out_d_bearing_d_px = bx_r;
  assign out_d_bearing_d_py = by_r;
  assign out_d_rate_d_px    = ra_r;
  assign out_d_rate_d_py    = rb_r;
  assign out_d_rate_d_vx    = rx_r;
  assign out_d_rate_d_vy    = ry_r;
  assign out_too_close      = tc_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_LAT))
    else $error("result without a matching accepted transaction");

  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_close |-> out_d_range_d_px == 0 && out_d_range_d_py == 0
      && out_d_bearing_d_px == 0 && out_d_bearing_d_py == 0
      && out_d_rate_d_px == 0 && out_d_rate_d_py == 0)
    else $error("rejected state gave a nonzero entry");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_d_range_d_px <= 32'sh0001_0000)
      && (out_d_range_d_px >= -32'sh0001_0000))
    else $error("x over range exceeds one");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && !busy)
    else $error("configuration port or input stalled");

endmodule
`default_nettype wire

### test/radar_measurement_jacobian_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core_tb
// Drives constant-velocity states through the radar Jacobian core, predicts
// every Jacobian with exact wide-integer arithmetic and compares each result
// field by field, across several settings of the squared-range threshold.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_core_tb;
  import rmj_pkg::*;

  typedef struct {
    logic [31:0] entry [8];
    logic        too_close;
  } jacobian_t;

  localparam int DRAIN_CYCLES = OUT_LAT + 12;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic signed [31:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic        out_valid;
  logic signed [31:0] out_d_range_d_px, out_d_range_d_py;
  logic signed [31:0] out_d_bearing_d_px, out_d_bearing_d_py;
  logic signed [31:0] out_d_rate_d_px, out_d_rate_d_py;
  logic signed [31:0] out_d_rate_d_vx, out_d_rate_d_vy;
  logic        out_too_close;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  jacobian_t   pending_jacobians [$];
  logic [CFG_W-1:0] range_threshold;
  int          mismatches = 0;
  int          states_sent = 0;
  int          states_rejected = 0;
  int          thresholds_written = 0;

  radar_measurement_jacobian_core dut (
    .clk, .rst_n, .start, .busy,
    .in_pos_x, .in_pos_y, .in_vel_x, .in_vel_y,
    .out_valid,
    .out_d_range_d_px, .out_d_range_d_py,
    .out_d_bearing_d_px, .out_d_bearing_d_py,
    .out_d_rate_d_px, .out_d_rate_d_py,
    .out_d_rate_d_vx, .out_d_rate_d_vy,
    .out_too_close,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_q16(input logic [63:0] mag, input logic neg,
                                            input logic over);
    if (neg) begin
      if (over || mag > 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (over || mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Quotient of a wide numerator by q; a quotient wider than 64 bits is overflow.
  function automatic logic [63:0] wide_div(input logic [127:0] num, input logic [63:0] q,
                                           output logic over);
    logic [127:0] quo;
    quo  = num / {64'd0, q};
    over = (quo[127:64] != 0);
    return quo[63:0];
  endfunction

  function automatic jacobian_t radar_jacobian(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] vx,
                                               input logic signed [31:0] vy);
    jacobian_t   j;
    longint      sx, sy, p1, p2;
    logic [63:0] ax, ay, q, m, w, u, cmag;
    logic [127:0] s;
    logic        over, cneg;
    sx = x; sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    q  = ax * ax + ay * ay;
    j.too_close = 1'b0;
    if (q == 0 || q < {24'd0, range_threshold}) begin
      foreach (j.entry[k]) j.entry[k] = '0;
      j.too_close = 1'b1;
      return j;
    end
    // Entries over the range.
    s = {64'd0, ax} << FRAC_BITS;
    w = wide_div(s * s, q, over);
    m = over ? '1 : int_sqrt(w);
    j.entry[0] = clamp_q16(m, sx < 0, 1'b0);
    s = {64'd0, ay} << FRAC_BITS;
    w = wide_div(s * s, q, over);
    m = over ? '1 : int_sqrt(w);
    j.entry[1] = clamp_q16(m, sy < 0, 1'b0);
    j.entry[6] = j.entry[0];
    j.entry[7] = j.entry[1];
    // Bearing entries over the squared range.
    m = wide_div({64'd0, ay} << (2 * FRAC_BITS), q, over);
    j.entry[2] = clamp_q16(m, !(sy < 0), over);
    m = wide_div({64'd0, ax} << (2 * FRAC_BITS), q, over);
    j.entry[3] = clamp_q16(m, sx < 0, over);
    // Range-rate entries over the range cubed.
    p1 = longint'(vx) * sy;
    p2 = longint'(vy) * sx;
    cneg = (p1 < p2);
    cmag = cneg ? 64'(p2 - p1) : 64'(p1 - p2);
    u = wide_div(({64'd0, ay} * {64'd0, cmag}) << FRAC_BITS, q, over);
    if (!over) begin
      w = wide_div({64'd0, u} * {64'd0, u}, q, over);
      m = int_sqrt(w);
    end
    j.entry[4] = clamp_q16(m, (sy < 0) != cneg, over);
    u = wide_div(({64'd0, ax} * {64'd0, cmag}) << FRAC_BITS, q, over);
    if (!over) begin
      w = wide_div({64'd0, u} * {64'd0, u}, q, over);
      m = int_sqrt(w);
    end
    j.entry[5] = clamp_q16(m, (sx < 0) == cneg, over);
    return j;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic send_state(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] vx, input logic [31:0] vy);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_pos_x = x; in_pos_y = y; in_vel_x = vx; in_vel_y = vy;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_jacobians.push_back(radar_jacobian(x, y, vx, vy));
    states_sent++;
  endtask

  task automatic quiesce;
    @(negedge clk);
    start = 1'b0;
    wait (pending_jacobians.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_W-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    range_threshold = value;
    thresholds_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Every result is checked against the oldest prediction in flight.
  always @(posedge clk) begin
    jacobian_t want;
    logic [31:0] got [8];
    if (rst_n && out_valid) begin
      got = '{out_d_range_d_px, out_d_range_d_py, out_d_bearing_d_px, out_d_bearing_d_py,
              out_d_rate_d_px, out_d_rate_d_py, out_d_rate_d_vx, out_d_rate_d_vy};
      if (pending_jacobians.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_jacobians.pop_front();
        if (want.too_close) states_rejected++;
        for (int k = 0; k < 8; k++)
          if (got[k] !== want.entry[k]) report_mismatch($sformatf("entry %0d", k),
                                                         got[k], want.entry[k]);
        if (out_too_close !== want.too_close)
          report_mismatch("too_close", 32'(out_too_close), 32'(want.too_close));
      end
    end
  end

  function automatic logic [31:0] random_field();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 255)
                                          : 32'h7FFF_FFFF - $urandom_range(0, 255);
    endcase
  endfunction

  task automatic test_directed;
    send_state(32'd0, 32'd0, 32'd5, 32'd7);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_state(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_state(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_state(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_state(32'd655, 32'd0, 32'd1, 32'd1);
    send_state(32'd656, 32'd0, 32'h8000_0000, 32'd1);
    // Threshold met exactly is accepted, states below it are rejected.
    write_threshold(40'd10000);
    send_state(32'd100, 32'd0, 32'h0001_0000, 32'd0);
    send_state(32'd99, 32'hFFFF_FFF2, 32'd3, 32'hFFFF_0000);
    send_state(32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    // A zero state is still rejected with the threshold at zero.
    write_threshold(40'd0);
    send_state(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_state(32'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(32'd0, 32'd1, 32'd0, 32'd0);
    write_threshold({CFG_W{1'b1}});
    send_state(32'h8000_0000, 32'h8000_0000, 32'd1, 32'd2);
    send_state(32'h0010_0000, 32'd0, 32'd1, 32'd2);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_state(random_field(), random_field(), random_field(), random_field());
  endtask

  task automatic test_thresholds;
    write_threshold(MIN_SQ_RST);
    test_random(100);
    write_threshold(40'd0);
    test_random(80);
    write_threshold({CFG_W{1'b1}});
    test_random(80);
    write_threshold({8'($urandom_range(0, 255)), $urandom()});
    test_random(80);
    write_threshold(40'h00_0100_0000);
    test_random(60);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_vel_x = '0; in_vel_y = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    range_threshold = MIN_SQ_RST;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_thresholds();
    quiesce();
    $display("Covered %0d states, %0d of them rejected as too close,", states_sent,
             states_rejected);
    $display("under %0d threshold settings including zero and the maximum.",
             thresholds_written + 1);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
